/* rtl/ffha_pkg.sv */
package ffha_pkg;

   // heap geometry
   localparam int HEAP_UNITS = 4096;
   localparam int UNIT_AW    = $clog2(HEAP_UNITS);
   localparam int LEN_W      = UNIT_AW;
   localparam int TOP_W      = UNIT_AW + 1;
   localparam int NEED_W     = 14;
   localparam int BYTES_W    = 16;
   localparam int ADDR_W     = 32;
   localparam int LIMIT_W    = 13;

   // register file
   localparam int CSR_AW = 3;
   localparam logic CSR_SEL_HEAP_BASE  = 1'b0;
   localparam logic CSR_SEL_HEAP_LIMIT = 1'b1;

   // request codes
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_WALK,
      ST_MERGE,
      ST_SPLIT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      OP_ALLOC,
      OP_ZERO,
      OP_FREE
   } op_type;

   // one header entry of the store
   typedef struct packed {
      logic             free;
      logic [LEN_W-1:0] len;
   } hdr_type;

   // finished result handed to the response register
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic              ok;
   } result_type;

   // byte address of heap unit u
   function automatic logic [ADDR_W-1:0] unit_addr(input logic [ADDR_W-1:0] base,
                                                   input logic [TOP_W-1:0] u);
      unit_addr = base + {{(ADDR_W - TOP_W - 3){1'b0}}, u, 3'b000};
   endfunction

endpackage

/* rtl/ffha_engine.sv */
module ffha_engine import ffha_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_type,
   input  logic [BYTES_W-1:0]  request_bytes,
   input  logic [ADDR_W-1:0]   block_addr,
   input  logic [ADDR_W-1:0]   heap_base,
   input  logic [LIMIT_W-1:0]  heap_limit,
   input  logic                slot_free,
   output logic                busy,
   output result_type          result
);

   // header store
   hdr_type mem [HEAP_UNITS];
   hdr_type rdata_ff;

   logic [UNIT_AW-1:0] rd_addr;
   logic               wr_en;
   logic [UNIT_AW-1:0] wr_addr;
   hdr_type            wr_data;

   // control and working registers
   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [NEED_W-1:0]  need_ff, need_in;
   logic [TOP_W-1:0]   cur_ff, cur_in;
   logic [UNIT_AW-1:0] target_ff, target_in;
   logic [LEN_W-1:0]   acc_ff, acc_in;
   logic [TOP_W-1:0]   top_ff, top_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic               res_ok_ff, res_ok_in;

   // datapath helpers
   logic [NEED_W-1:0]  need_req;
   logic [ADDR_W-1:0]  off;
   logic [ADDR_W-4:0]  tgt_w;
   logic               free_bad;
   logic [TOP_W-1:0]   eff_limit;
   logic [TOP_W+1:0]   grow_sum;
   logic               grow_fits;
   logic [TOP_W-1:0]   nxt;
   logic               nxt_in_heap;
   logic [LEN_W-1:0]   acc_sum;
   logic               walk_end;

   assign need_req  = NEED_W'(({1'b0, request_bytes} + 17'd7) >> 3);
   assign off       = block_addr - heap_base;
   assign tgt_w     = off[ADDR_W-1:3] - 29'd1;
   assign free_bad  = (block_addr == '0) || (off[2:0] != 3'd0) ||
                      (off[ADDR_W-1:3] == '0) || (tgt_w >= (ADDR_W-3)'(top_ff));
   assign eff_limit = (heap_limit > LIMIT_W'(HEAP_UNITS)) ? TOP_W'(HEAP_UNITS)
                                                         : TOP_W'(heap_limit);
   assign grow_sum  = (TOP_W+2)'(top_ff) + (TOP_W+2)'(need_ff) + (TOP_W+2)'(1);
   assign grow_fits = grow_sum <= (TOP_W+2)'(eff_limit);
   assign nxt       = cur_ff + TOP_W'(rdata_ff.len) + TOP_W'(1);
   assign nxt_in_heap = nxt < top_ff;
   assign acc_sum   = acc_ff + rdata_ff.len + LEN_W'(1);

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         top_ff   <= '0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
      end
      op_ff       <= op_in;
      need_ff     <= need_in;
      cur_ff      <= cur_in;
      target_ff   <= target_in;
      acc_ff      <= acc_in;
      res_addr_ff <= res_addr_in;
      res_ok_ff   <= res_ok_in;
   end

   // walk sequencer
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      need_in     = need_ff;
      cur_in      = cur_ff;
      target_in   = target_ff;
      acc_in      = acc_ff;
      top_in      = top_ff;
      res_addr_in = res_addr_ff;
      res_ok_in   = res_ok_ff;
      rd_addr     = cur_ff[UNIT_AW-1:0];
      wr_en       = 1'b0;
      wr_addr     = cur_ff[UNIT_AW-1:0];
      wr_data     = '0;
      walk_end    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cur_in = '0;
               if (req_type == REQ_FREE) begin
                  op_in     = OP_FREE;
                  target_in = tgt_w[UNIT_AW-1:0];
                  if (free_bad) begin
                     res_addr_in = '0;
                     res_ok_in   = 1'b1;
                     state_in    = ST_DONE;
                  end else begin
                     state_in = ST_START;
                  end
               end else begin
                  need_in  = need_req;
                  op_in    = (need_req == '0) ? OP_ZERO : OP_ALLOC;
                  state_in = ST_START;
               end
            end
         end

         // header 0 read goes out here
         ST_START: begin
            if (top_ff == '0) begin
               walk_end = 1'b1;
            end else begin
               state_in = ST_WALK;
            end
         end

         // one header per cycle, next read issued from the current length
         ST_WALK: begin
            case (op_ff)
               OP_ZERO: begin
                  if (rdata_ff.len == '0 && !rdata_ff.free) begin
                     res_addr_in = unit_addr(heap_base, cur_ff);
                     res_ok_in   = 1'b1;
                     state_in    = ST_DONE;
                  end else if (nxt_in_heap) begin
                     cur_in  = nxt;
                     rd_addr = nxt[UNIT_AW-1:0];
                  end else begin
                     walk_end = 1'b1;
                  end
               end
               OP_ALLOC: begin
                  if (rdata_ff.free && NEED_W'(rdata_ff.len) >= need_ff) begin
                     wr_en       = 1'b1;
                     wr_data     = '{free: 1'b0, len: need_ff[LEN_W-1:0]};
                     res_addr_in = unit_addr(heap_base, cur_ff + TOP_W'(1));
                     res_ok_in   = 1'b1;
                     if (NEED_W'(rdata_ff.len) != need_ff) begin
                        acc_in   = rdata_ff.len - need_ff[LEN_W-1:0] - LEN_W'(1);
                        cur_in   = cur_ff + TOP_W'(need_ff[LEN_W-1:0]) + TOP_W'(1);
                        state_in = ST_SPLIT;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end else if (nxt_in_heap) begin
                     cur_in  = nxt;
                     rd_addr = nxt[UNIT_AW-1:0];
                  end else begin
                     walk_end = 1'b1;
                  end
               end
               OP_FREE: begin
                  if (cur_ff == TOP_W'(target_ff)) begin
                     acc_in = rdata_ff.len;
                     if (nxt_in_heap) begin
                        cur_in   = nxt;
                        rd_addr  = nxt[UNIT_AW-1:0];
                        state_in = ST_MERGE;
                     end else begin
                        wr_en       = 1'b1;
                        wr_addr     = target_ff;
                        wr_data     = '{free: 1'b1, len: rdata_ff.len};
                        res_addr_in = '0;
                        res_ok_in   = 1'b1;
                        state_in    = ST_DONE;
                     end
                  end else if (nxt_in_heap) begin
                     cur_in  = nxt;
                     rd_addr = nxt[UNIT_AW-1:0];
                  end else begin
                     walk_end = 1'b1;
                  end
               end
               default: begin
                  walk_end = 1'b1;
               end
            endcase
         end

         // absorb following free blocks, header written once at the end
         ST_MERGE: begin
            if (rdata_ff.free) begin
               acc_in = acc_sum;
               if (nxt_in_heap) begin
                  cur_in  = nxt;
                  rd_addr = nxt[UNIT_AW-1:0];
               end else begin
                  wr_en       = 1'b1;
                  wr_addr     = target_ff;
                  wr_data     = '{free: 1'b1, len: acc_sum};
                  res_addr_in = '0;
                  res_ok_in   = 1'b1;
                  state_in    = ST_DONE;
               end
            end else begin
               wr_en       = 1'b1;
               wr_addr     = target_ff;
               wr_data     = '{free: 1'b1, len: acc_ff};
               res_addr_in = '0;
               res_ok_in   = 1'b1;
               state_in    = ST_DONE;
            end
         end

         // remainder header of a split block
         ST_SPLIT: begin
            wr_en    = 1'b1;
            wr_data  = '{free: 1'b1, len: acc_ff};
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // end of the header list reached without a hit
      if (walk_end) begin
         state_in = ST_DONE;
         case (op_ff)
            OP_ALLOC: begin
               if (grow_fits) begin
                  wr_en       = 1'b1;
                  wr_addr     = top_ff[UNIT_AW-1:0];
                  wr_data     = '{free: 1'b0, len: need_ff[LEN_W-1:0]};
                  top_in      = grow_sum[TOP_W-1:0];
                  res_addr_in = unit_addr(heap_base, top_ff + TOP_W'(1));
                  res_ok_in   = 1'b1;
               end else begin
                  res_addr_in = '0;
                  res_ok_in   = 1'b0;
               end
            end
            OP_FREE: begin
               res_addr_in = '0;
               res_ok_in   = 1'b1;
            end
            default: begin
               res_addr_in = '0;
               res_ok_in   = 1'b0;
            end
         endcase
      end
   end

   assign busy         = state_ff != ST_IDLE;
   assign result.valid = (state_ff == ST_DONE) && slot_free;
   assign result.addr  = res_addr_ff;
   assign result.ok    = res_ok_ff;

endmodule

/* rtl/first_fit_heap_allocator.sv */
// First-fit heap allocator over an implicit list of 8-byte-unit headers kept in a
// 4096-entry header memory. One request is handled at a time: the block walks the
// header list from unit 0 and visits one header per clock, since each next header
// address comes from the length read out of the registered read port of the header
// memory. A request visits the headers in order up to a hit or the heap top; a free
// then merges the following free neighbors, and an allocation that splits a block
// writes a remainder header. The result sits in an output register, so the next
// request is taken while it waits. The header memory needs no clearing after reset;
// only headers that were written are ever read.
module first_fit_heap_allocator import ffha_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [BYTES_W-1:0]  req_request_bytes,
   input  logic [ADDR_W-1:0]   req_block_addr,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ADDR_W-1:0]   rsp_result_addr,
   output logic                rsp_ok,
   // register port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   logic [ADDR_W-1:0]  heap_base_ff;
   logic [LIMIT_W-1:0] heap_limit_ff;
   logic               csr_wr;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   logic               rsp_ok_ff;

   logic               busy;
   logic               slot_free;
   result_type         result;

   // register writes
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff  <= '0;
         heap_limit_ff <= LIMIT_W'(HEAP_UNITS);
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            CSR_SEL_HEAP_BASE:  heap_base_ff  <= csr_pwdata;
            CSR_SEL_HEAP_LIMIT: heap_limit_ff <= csr_pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_paddr[2])
         CSR_SEL_HEAP_BASE:  csr_prdata = heap_base_ff;
         CSR_SEL_HEAP_LIMIT: csr_prdata = 32'(heap_limit_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // walk engine and header memory
   assign req_stall = busy;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   ffha_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .start         (req_valid && !req_stall),
      .req_type      (req_type),
      .request_bytes (req_request_bytes),
      .block_addr    (req_block_addr),
      .heap_base     (heap_base_ff),
      .heap_limit    (heap_limit_ff),
      .slot_free     (slot_free),
      .busy          (busy),
      .result        (result)
   );

   // response register, loaded when the slot is empty or its transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (result.valid) begin
         rsp_addr_ff <= result.addr;
         rsp_ok_ff   <= result.ok;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_addr = rsp_addr_ff;
   assign rsp_ok          = rsp_ok_ff;

endmodule

/* sim/testbench.sv */
module testbench;
   import ffha_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALE_LIMIT = 40000;
   localparam int NROWS       = 28;
   localparam logic [CSR_AW-1:0] ADDR_HEAP_BASE  = {CSR_SEL_HEAP_BASE, 2'b00};
   localparam logic [CSR_AW-1:0] ADDR_HEAP_LIMIT = {CSR_SEL_HEAP_LIMIT, 2'b00};

   typedef enum logic [1:0] {
      ROW_REQ,
      ROW_BASE,
      ROW_LIMIT
   } row_kind_type;

   // one line of the directed plan; register rows carry the value in addr
   typedef struct packed {
      row_kind_type      kind;
      logic              rtype;
      logic [15:0]       bytes;
      logic [31:0]       addr;
      logic              typed;
      logic [31:0]       exp_addr;
      logic              exp_ok;
   } stim_row_type;

   typedef struct packed {
      logic [31:0] addr;
      logic        ok;
   } heap_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_type = REQ_ALLOC;
   logic [BYTES_W-1:0]  req_request_bytes = '0;
   logic [ADDR_W-1:0]   req_block_addr = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [ADDR_W-1:0]   rsp_result_addr;
   logic                rsp_ok;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   first_fit_heap_allocator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_request_bytes (req_request_bytes),
      .req_block_addr    (req_block_addr),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_addr   (rsp_result_addr),
      .rsp_ok            (rsp_ok),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #2 clock = ~clock;

   // shadow heap: header list, top and registers
   logic [15:0]  hdr_len  [HEAP_UNITS];
   logic         hdr_free [HEAP_UNITS];
   int unsigned  top_units = 0;
   logic [31:0]  base_addr = '0;
   logic [12:0]  limit_units = 13'd4096;

   heap_reply_type due_replies[$];
   int             errors = 0;
   stim_row_type   plan [NROWS];

   // driver side knobs
   int           snd_idle_pct = 0;
   int           rsp_stall_pct = 0;
   int           rsp_hold_left = 0;
   logic         row_typed = 1'b0;
   logic [31:0]  row_exp_addr = '0;
   logic         row_exp_ok = 1'b0;

   function automatic logic [31:0] addr_of(input int unsigned u);
      return base_addr + 32'(u * 8);
   endfunction

   function automatic void put_hdr(input int unsigned u, input int unsigned len,
                                   input logic is_free);
      if (u < HEAP_UNITS) begin
         hdr_len[u]  = 16'(len);
         hdr_free[u] = is_free;
      end
   endfunction

   // first-fit allocate, zero size looks for an in-use empty block
   function automatic void predict_alloc(input logic [15:0] bytes,
                                         output logic [31:0] a, output logic ok);
      int unsigned need, cur, spare, lim;
      need = (32'(bytes) + 7) / 8;
      cur  = 0;
      a    = '0;
      ok   = 1'b0;
      lim  = (limit_units > HEAP_UNITS) ? HEAP_UNITS : 32'(limit_units);
      if (need == 0) begin
         while (cur < top_units && !ok) begin
            if (hdr_len[cur] == 0 && !hdr_free[cur]) begin
               a  = addr_of(cur);
               ok = 1'b1;
            end else begin
               cur = cur + hdr_len[cur] + 1;
            end
         end
         return;
      end
      while (cur < top_units && !ok) begin
         if (hdr_free[cur] && hdr_len[cur] >= need) begin
            spare = hdr_len[cur] - need;
            put_hdr(cur, need, 1'b0);
            if (spare >= 1)
               put_hdr(cur + need + 1, spare - 1, 1'b1);
            a  = addr_of(cur + 1);
            ok = 1'b1;
         end else begin
            cur = cur + hdr_len[cur] + 1;
         end
      end
      // grow the heap top when nothing fits
      if (!ok && top_units + need + 1 <= lim) begin
         put_hdr(top_units, need, 1'b0);
         a         = addr_of(top_units + 1);
         top_units = top_units + need + 1;
         ok        = 1'b1;
      end
   endfunction

   // mark free and merge following free blocks up to the top
   function automatic void predict_free(input logic [31:0] a);
      logic [31:0] off;
      int unsigned tgt, cur, nxt, aft;
      if (a == 0)
         return;
      off = a - base_addr;
      if (off[2:0] != 3'd0 || off < 8)
         return;
      tgt = (off >> 3) - 1;
      if (tgt >= top_units)
         return;
      cur = 0;
      while (cur < top_units && cur != tgt)
         cur = cur + hdr_len[cur] + 1;
      if (cur != tgt)
         return;
      hdr_free[tgt] = 1'b1;
      nxt = tgt + hdr_len[tgt] + 1;
      while (nxt < top_units && hdr_free[nxt]) begin
         aft = nxt + hdr_len[nxt] + 1;
         hdr_len[tgt] = 16'(hdr_len[tgt] + hdr_len[nxt] + 1);
         nxt = aft;
      end
   endfunction

   // payload address of a block on the list, mostly an in-use one
   function automatic logic [31:0] pick_block_addr();
      int unsigned cur;
      int unsigned used[$];
      int unsigned any[$];
      cur = 0;
      while (cur < top_units) begin
         any.push_back(cur);
         if (!hdr_free[cur])
            used.push_back(cur);
         cur = cur + hdr_len[cur] + 1;
      end
      if (any.size() == 0)
         return addr_of(1);
      if (used.size() != 0 && $urandom_range(99) < 75)
         return addr_of(used[$urandom_range(used.size() - 1)] + 1);
      return addr_of(any[$urandom_range(any.size() - 1)] + 1);
   endfunction

   // response check and request prediction, both at the rising edge
   always @(posedge clock) begin : monitor
      heap_reply_type want;
      logic [31:0] pa;
      logic        pok;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_replies.size() == 0) begin
               errors++;
               $display("%0t: unexpected transfer, expected none, actual addr %h ok %b",
                        $time, rsp_result_addr, rsp_ok);
            end else begin
               want = due_replies.pop_front();
               if (rsp_result_addr !== want.addr) begin
                  errors++;
                  $display("%0t: result_addr expected %h actual %h",
                           $time, want.addr, rsp_result_addr);
               end
               if (rsp_ok !== want.ok) begin
                  errors++;
                  $display("%0t: ok expected %b actual %b", $time, want.ok, rsp_ok);
               end
            end
         end
         if (req_valid && !req_stall) begin
            pa  = '0;
            pok = 1'b1;
            if (req_type == REQ_ALLOC)
               predict_alloc(req_request_bytes, pa, pok);
            else
               predict_free(req_block_addr);
            if (row_typed)
               due_replies.push_back('{row_exp_addr, row_exp_ok});
            else
               due_replies.push_back('{pa, pok});
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin : watchdog
      int stale;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stale = 0;
      else
         stale = stale + 1;
      if (stale >= STALE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver stalls, with an optional long hold-off
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall     <= 1'b1;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // offer one request and wait for its transfer
   task automatic send_item(input logic rtype, input logic [15:0] bytes,
                            input logic [31:0] baddr, input logic typed,
                            input logic [31:0] xa, input logic xo);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= rtype;
      req_request_bytes <= bytes;
      req_block_addr    <= baddr;
      row_typed    = typed;
      row_exp_addr = xa;
      row_exp_ok   = xo;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   // let every expected result arrive, block left idle
   task automatic drain_all();
      req_valid <= 1'b0;
      while (due_replies.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // register write: setup then access, then read back the same register
   task automatic write_reg(input logic [CSR_AW-1:0] a, input logic [31:0] v);
      logic [31:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= a;
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      if (a == ADDR_HEAP_BASE) begin
         base_addr = v;
         want      = v;
      end else begin
         limit_units = v[12:0];
         want        = {19'd0, v[12:0]};
      end
      // read back: setup then access
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      if (csr_prdata !== want) begin
         errors++;
         $display("%0t: register read expected %h actual %h", $time, want, csr_prdata);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // idle knobs change away from the falling edge
   task automatic set_idling(input int snd, input int rcv, input int hold);
      @(posedge clock);
      snd_idle_pct  = snd;
      rsp_stall_pct = rcv;
      rsp_hold_left = hold;
      @(negedge clock);
   endtask

   // random mix, mostly live blocks for frees
   task automatic run_random(input int n);
      logic [15:0] nb;
      logic [31:0] na;
      int          k;
      for (int i = 0; i < n; i++) begin
         nb = 16'($urandom);
         na = $urandom;
         if ($urandom_range(99) < 55) begin
            k = $urandom_range(99);
            if (k < 5)
               nb = 16'd0;
            else if (k < 70)
               nb = 16'($urandom_range(1, 64));
            else if (k < 85)
               nb = 16'($urandom_range(65, 512));
            else if (k < 93)
               nb = 16'($urandom_range(513, 32768));
            send_item(REQ_ALLOC, nb, na, 1'b0, '0, 1'b0);
         end else begin
            k = $urandom_range(99);
            if (k < 5)
               na = '0;
            else if (k < 80)
               na = pick_block_addr();
            else if (k < 88)
               na = $urandom;
            else if (k < 94)
               na = pick_block_addr() + 32'($urandom_range(1, 7));
            else
               na = pick_block_addr() - 32'd8;
            send_item(REQ_FREE, nb, na, 1'b0, '0, 1'b0);
         end
      end
   endtask

   initial begin : stimulus
      for (int u = 0; u < HEAP_UNITS; u++) begin
         hdr_len[u]  = '0;
         hdr_free[u] = 1'b0;
      end

      // directed plan, heap empty, base 0, limit 4096
      // zero size on an empty heap
      plan[0]  = '{ROW_REQ, REQ_ALLOC, 16'd0, 32'd0, 1'b1, 32'd0, 1'b0};
      plan[1]  = '{ROW_REQ, REQ_ALLOC, 16'd1, 32'd0, 1'b1, 32'd8, 1'b1};
      plan[2]  = '{ROW_REQ, REQ_ALLOC, 16'd8, 32'hFFFF_FFFF, 1'b1, 32'd24, 1'b1};
      plan[3]  = '{ROW_REQ, REQ_ALLOC, 16'd9, 32'd0, 1'b1, 32'd40, 1'b1};
      // null, misaligned, not a block, plain free, double free
      plan[4]  = '{ROW_REQ, REQ_FREE, 16'hFFFF, 32'd0, 1'b1, 32'd0, 1'b1};
      plan[5]  = '{ROW_REQ, REQ_FREE, 16'd0, 32'd12, 1'b1, 32'd0, 1'b1};
      plan[6]  = '{ROW_REQ, REQ_FREE, 16'd0, 32'd16, 1'b1, 32'd0, 1'b1};
      plan[7]  = '{ROW_REQ, REQ_FREE, 16'd0, 32'd24, 1'b1, 32'd0, 1'b1};
      plan[8]  = '{ROW_REQ, REQ_FREE, 16'd0, 32'd24, 1'b1, 32'd0, 1'b1};
      // zero size with no empty in-use block, oversize requests
      plan[9]  = '{ROW_REQ, REQ_ALLOC, 16'd0, 32'd0, 1'b1, 32'd0, 1'b0};
      plan[10] = '{ROW_REQ, REQ_ALLOC, 16'hFFFF, 32'd0, 1'b1, 32'd0, 1'b0};
      plan[11] = '{ROW_REQ, REQ_ALLOC, 16'd32768, 32'd0, 1'b1, 32'd0, 1'b0};
      // free at the top, merge, split, exact fit
      plan[12] = '{ROW_REQ, REQ_FREE, 16'd0, 32'd40, 1'b0, 32'd0, 1'b0};
      plan[13] = '{ROW_REQ, REQ_FREE, 16'd0, 32'd24, 1'b0, 32'd0, 1'b0};
      plan[14] = '{ROW_REQ, REQ_ALLOC, 16'd16, 32'd0, 1'b0, 32'd0, 1'b0};
      plan[15] = '{ROW_REQ, REQ_ALLOC, 16'd1, 32'd0, 1'b0, 32'd0, 1'b0};
      plan[16] = '{ROW_REQ, REQ_FREE, 16'd0, 32'd8, 1'b0, 32'd0, 1'b0};
      // growth past the limit, free far past the top
      plan[17] = '{ROW_REQ, REQ_ALLOC, 16'd32760, 32'd0, 1'b0, 32'd0, 1'b0};
      plan[18] = '{ROW_REQ, REQ_FREE, 16'd0, 32'hFFFF_FFF8, 1'b0, 32'd0, 1'b0};
      // base moved to the top of the address space, limit above heap size
      plan[19] = '{ROW_BASE, REQ_ALLOC, 16'd0, 32'hFFFF_FFF8, 1'b0, 32'd0, 1'b0};
      plan[20] = '{ROW_LIMIT, REQ_ALLOC, 16'd0, 32'd8191, 1'b0, 32'd0, 1'b0};
      plan[21] = '{ROW_REQ, REQ_ALLOC, 16'd3, 32'd0, 1'b0, 32'd0, 1'b0};
      plan[22] = '{ROW_REQ, REQ_FREE, 16'd0, 32'd16, 1'b0, 32'd0, 1'b0};
      // limit below the heap top
      plan[23] = '{ROW_LIMIT, REQ_ALLOC, 16'd0, 32'd1, 1'b0, 32'd0, 1'b0};
      plan[24] = '{ROW_REQ, REQ_ALLOC, 16'd200, 32'd0, 1'b0, 32'd0, 1'b0};
      plan[25] = '{ROW_REQ, REQ_ALLOC, 16'd8, 32'd0, 1'b0, 32'd0, 1'b0};
      plan[26] = '{ROW_BASE, REQ_ALLOC, 16'd0, 32'd0, 1'b0, 32'd0, 1'b0};
      plan[27] = '{ROW_LIMIT, REQ_ALLOC, 16'd0, 32'd4096, 1'b0, 32'd0, 1'b0};

      repeat (5) @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NROWS; i++) begin
         case (plan[i].kind)
            ROW_REQ: begin
               send_item(plan[i].rtype, plan[i].bytes, plan[i].addr, plan[i].typed,
                         plan[i].exp_addr, plan[i].exp_ok);
            end
            ROW_BASE: begin
               drain_all();
               write_reg(ADDR_HEAP_BASE, plan[i].addr);
            end
            default: begin
               drain_all();
               write_reg(ADDR_HEAP_LIMIT, plan[i].addr);
            end
         endcase
      end

      // random phases, each with its own settings and idling
      for (int p = 0; p < 4; p++) begin
         drain_all();
         write_reg(ADDR_HEAP_BASE, $urandom & ~32'h7);
         case (p)
            0: begin
               write_reg(ADDR_HEAP_LIMIT, 32'd4096);
               set_idling(0, 0, 0);
            end
            1: begin
               write_reg(ADDR_HEAP_LIMIT, 32'($urandom_range(40, 200)));
               set_idling(60, 0, 0);
            end
            2: begin
               write_reg(ADDR_HEAP_LIMIT, 32'd8191);
               set_idling(0, 60, 0);
            end
            default: begin
               write_reg(ADDR_HEAP_LIMIT, 32'($urandom_range(1, 4096)));
               set_idling(23, 23, 0);
            end
         endcase
         run_random(30);
      end

      // long receiver hold-off while requests keep coming
      drain_all();
      write_reg(ADDR_HEAP_LIMIT, 32'd4096);
      set_idling(0, 0, 250);
      run_random(12);

      drain_all();
      repeat (20) @(negedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* files.f */
rtl/ffha_pkg.sv
rtl/ffha_engine.sv
rtl/first_fit_heap_allocator.sv
sim/testbench.sv
